>>> design/drcm_pkg.sv
package drcm_pkg;

  // Default store depth and field widths
  localparam int MAX_CLUSTERS_DEF = 32;
  localparam int OP_W             = 2;
  localparam int ETA_W            = 18;
  localparam int PHI_W            = 16;
  localparam int TIME_W           = 16;
  localparam int STATUS_W         = 2;
  localparam int INDEX_W          = 6;
  localparam int THRESH_W         = 37;

  // 0.04 rad^2 expressed in (2*pi/65536)^2 units
  localparam logic [THRESH_W-1:0] THRESH_RESET = 37'd4352000;

  // Operation codes carried by an input item
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MATCH = 2'd2
  } op_t;

  // Status codes carried by a result item
  typedef enum logic [STATUS_W-1:0] {
    STAT_CLEARED = 2'd0,
    STAT_STORED  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MATCHED = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic found;
    logic all_issued;
    logic pipe_empty;
  } dp_status_t;

endpackage

>>> design/drcm_if.sv
interface drcm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [drcm_pkg::OP_W-1:0]            op;
  logic signed [drcm_pkg::ETA_W-1:0]    eta;
  logic signed [drcm_pkg::PHI_W-1:0]    phi;
  logic signed [drcm_pkg::TIME_W-1:0]   time_value;

  modport source (output valid, op, eta, phi, time_value, input ready);
  modport sink   (input valid, op, eta, phi, time_value, output ready);
endinterface

interface drcm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [drcm_pkg::STATUS_W-1:0]        status;
  logic signed [drcm_pkg::INDEX_W-1:0]  match_index;
  logic signed [drcm_pkg::TIME_W-1:0]   match_time;

  modport source (output valid, status, match_index, match_time, input ready);
  modport sink   (input valid, status, match_index, match_time, output ready);
endinterface

>>> design/drcm_ctrl.sv
module drcm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [drcm_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  input  drcm_pkg::dp_status_t      stat,
  output drcm_pkg::ctl_cmd_t        cmd
);
  import drcm_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands. An item is taken only when the result
  // register is free, so a clear or load can post its result at once.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        cmd.take = in_ready && in_valid;
        if (cmd.take && (in_op == OP_MATCH)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one stored cluster per cycle until all are issued or a hit comes back
        cmd.step   = !stat.all_issued && !stat.found;
        cmd.finish = stat.found || (stat.all_issued && stat.pipe_empty);
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/drcm_dpath.sv
module drcm_dpath #(
  parameter int MAX_CLUSTERS = drcm_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [drcm_pkg::OP_W-1:0]            in_op,
  input  logic signed [drcm_pkg::ETA_W-1:0]    in_eta,
  input  logic signed [drcm_pkg::PHI_W-1:0]    in_phi,
  input  logic signed [drcm_pkg::TIME_W-1:0]   in_time,
  input  logic                                 cfg_we,
  input  logic [drcm_pkg::THRESH_W-1:0]        cfg_wdata,
  input  drcm_pkg::ctl_cmd_t                   cmd,
  output drcm_pkg::dp_status_t                 stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [drcm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [drcm_pkg::INDEX_W-1:0]  out_index,
  output logic signed [drcm_pkg::TIME_W-1:0]   out_time
);
  import drcm_pkg::*;

  localparam int AW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CW    = $clog2(MAX_CLUSTERS + 1);
  localparam int EW    = ETA_W + PHI_W + TIME_W;
  localparam int DE_W  = ETA_W + 1;
  localparam int DEP_W = 2 * DE_W;
  localparam int DPP_W = 2 * PHI_W;
  localparam int DPS_W = DPP_W - 1;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CLUSTERS);

  // Cluster store, one packed entry of eta, phi and time per cluster
  logic [EW-1:0]              mem [MAX_CLUSTERS];
  logic [EW-1:0]              rd_data_r;

  logic [THRESH_W-1:0]        thresh_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              scan_idx_r;
  logic signed [ETA_W-1:0]    q_eta_r;
  logic signed [PHI_W-1:0]    q_phi_r;

  // Compare pipeline
  logic                       v1_r;
  logic [AW-1:0]              idx1_r;
  logic                       v2_r;
  logic [AW-1:0]              idx2_r;
  logic [THRESH_W-1:0]        de_sq_r;
  logic [DPS_W-1:0]           dp_sq_r;
  logic signed [TIME_W-1:0]   time2_r;
  logic                       found_r;
  logic [AW-1:0]              found_idx_r;
  logic signed [TIME_W-1:0]   found_time_r;

  // Result register
  logic                       out_valid_r;
  logic [STATUS_W-1:0]        out_status_r;
  logic signed [INDEX_W-1:0]  out_index_r;
  logic signed [TIME_W-1:0]   out_time_r;

  logic                       take_clear;
  logic                       take_load;
  logic                       take_match;
  logic                       load_ok;
  logic                       out_wr;
  logic signed [ETA_W-1:0]    c_eta;
  logic signed [PHI_W-1:0]    c_phi;
  logic signed [TIME_W-1:0]   c_time;
  logic signed [DE_W-1:0]     de;
  logic signed [PHI_W-1:0]    dp;
  logic signed [DEP_W-1:0]    de_prod;
  logic signed [DPP_W-1:0]    dp_prod;
  logic [THRESH_W-1:0]        dist_sq;
  logic                       hit;

  // Command decode
  always_comb begin
    take_clear = cmd.take && (in_op == OP_CLEAR);
    take_load  = cmd.take && (in_op == OP_LOAD);
    take_match = cmd.take && (in_op == OP_MATCH);
    load_ok    = take_load && (count_r != COUNT_FULL);
    out_wr     = take_clear || take_load || cmd.finish;
  end

  // Store write at the fill count, registered read at the scan pointer
  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[count_r[AW-1:0]] <= {in_eta, in_phi, in_time};
    end
    if (cmd.step) begin
      rd_data_r <= mem[scan_idx_r[AW-1:0]];
    end
  end

  // Differences and squares of the entry just read; phi wraps in 16 bits
  always_comb begin
    c_eta   = signed'(rd_data_r[EW-1 -: ETA_W]);
    c_phi   = signed'(rd_data_r[TIME_W +: PHI_W]);
    c_time  = signed'(rd_data_r[TIME_W-1:0]);
    de      = DE_W'(q_eta_r) - DE_W'(c_eta);
    dp      = q_phi_r - c_phi;
    de_prod = de * de;
    dp_prod = dp * dp;
  end

  // Sum and threshold compare
  always_comb begin
    dist_sq = de_sq_r + THRESH_W'(dp_sq_r);
    hit     = v2_r && (dist_sq < thresh_r);
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      count_r     <= '0;
      scan_idx_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (take_clear) begin
        count_r <= '0;
      end else if (load_ok) begin
        count_r <= count_r + 1'b1;
      end
      if (take_match) begin
        scan_idx_r <= '0;
      end else if (cmd.step) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      v1_r <= cmd.step;
      v2_r <= v1_r && !cmd.finish;
      if (take_match) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload; the first hit in load order is kept
  always_ff @(posedge clk) begin
    if (take_match) begin
      q_eta_r <= in_eta;
      q_phi_r <= in_phi;
    end
    idx1_r  <= scan_idx_r[AW-1:0];
    idx2_r  <= idx1_r;
    de_sq_r <= de_prod[THRESH_W-1:0];
    dp_sq_r <= dp_prod[DPS_W-1:0];
    time2_r <= c_time;
    if (hit && !found_r) begin
      found_idx_r  <= idx2_r;
      found_time_r <= time2_r;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take_clear) begin
      out_status_r <= STAT_CLEARED;
      out_index_r  <= '0;
      out_time_r   <= '0;
    end else if (take_load) begin
      out_status_r <= load_ok ? STAT_STORED : STAT_FULL;
      out_index_r  <= '0;
      out_time_r   <= '0;
    end else if (cmd.finish) begin
      out_status_r <= STAT_MATCHED;
      out_index_r  <= found_r ? signed'(INDEX_W'(found_idx_r)) : '1;
      out_time_r   <= found_r ? found_time_r : '0;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.out_free   = !out_valid_r || out_ready;
    stat.found      = found_r;
    stat.all_issued = (scan_idx_r == count_r);
    stat.pipe_empty = !v1_r && !v2_r;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_time   = out_time_r;

endmodule

>>> design/delta_r_first_cluster_match.sv
// Channel  Dir  Payload                         Handshake
// in_ch    in   op, eta, phi, time_value        valid/ready
// out_ch   out  status, match_index, match_time valid/ready
// cfg      in   cfg_wdata (threshold)           cfg_we, no wait
//
// Clear and load items post their result at the accept edge. A match item scans the
// stored clusters in load order up to the first hit or the end of the store: the
// single store read port gives one cluster a cycle, followed by a three-stage square
// and compare pipeline. Reset is synchronous and active low; it empties the store
// count and loads the default threshold. A new item is taken only when the result
// register is empty or being read, so a stalled output holds the block in idle.
module delta_r_first_cluster_match #(
  parameter int MAX_CLUSTERS = drcm_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  drcm_in_if.sink                       in_ch,
  drcm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [drcm_pkg::THRESH_W-1:0] cfg_wdata
);
  import drcm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;
  logic       in_ready;

  // Sequencer
  drcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, compare pipeline and result register
  drcm_dpath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_ch.op),
    .in_eta     (in_ch.eta),
    .in_phi     (in_ch.phi),
    .in_time    (in_ch.time_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_index  (out_ch.match_index),
    .out_time   (out_ch.match_time)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> design/drcm_checker.sv
module drcm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [drcm_pkg::OP_W-1:0]            in_op,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [drcm_pkg::STATUS_W-1:0]        out_status,
  input logic signed [drcm_pkg::INDEX_W-1:0]  out_index,
  input logic signed [drcm_pkg::TIME_W-1:0]   out_time
);
  import drcm_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_index) && $stable(out_time))
    else $error("result changed while stalled");

  // No item is taken while an unread result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("item taken over a pending result");

  // A clear answers in the next cycle.
  a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_CLEAR) |=>
      out_valid && (out_status == STAT_CLEARED))
    else $error("clear did not answer at once");

  // Non-match results carry zero index and time; a miss carries zero time.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status != STAT_MATCHED) ||
      (out_index == -6'sd1)) |-> (out_time == '0) &&
      ((out_status == STAT_MATCHED) || (out_index == '0)))
    else $error("unexpected index or time in result");

endmodule

bind delta_r_first_cluster_match drcm_checker u_drcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.match_index),
  .out_time   (out_ch.match_time)
);

>>> tb/tb_delta_r_first_cluster_match.sv
`timescale 1ns / 100ps

module tb_delta_r_first_cluster_match;
  import drcm_pkg::*;

  localparam int N_CLUSTERS   = MAX_CLUSTERS_DEF;
  localparam int ITEM_TARGET  = 1750;
  localparam int PHASE_ITEMS  = 240;
  localparam int SETTLE_TICKS = N_CLUSTERS + 10;
  localparam int IDLE_PCT     = 26;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};

  // One result item as the block should deliver it.
  typedef struct packed {
    status_t                     status;
    logic signed [INDEX_W-1:0]   match_index;
    logic signed [TIME_W-1:0]    match_time;
  } cluster_answer_t;

  localparam cluster_answer_t NO_ANSWER = '{STAT_CLEARED, 6'sd0, 16'sd0};

  // One row of the directed table; a typed answer is pushed instead of the predicted one.
  typedef struct packed {
    logic [OP_W-1:0]             op;
    logic signed [ETA_W-1:0]     eta;
    logic signed [PHI_W-1:0]     phi;
    logic signed [TIME_W-1:0]    tv;
    logic [5:0]                  reps;
    logic                        typed;
    cluster_answer_t             ans;
  } stim_row_t;

  localparam int N_ROWS = 21;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // Empty store straight after reset.
    '{OP_MATCH, 18'sd0, 16'sd0, 16'sd0, 6'd1, 1'b1, '{STAT_MATCHED, -6'sd1, 16'sd0}},
    // Unused operation: no result.
    '{OP_UNUSED, 18'sd5, 16'sd5, 16'sd5, 6'd1, 1'b0, NO_ANSWER},
    '{OP_CLEAR, 18'sd0, 16'sd0, 16'sd0, 6'd1, 1'b1, '{STAT_CLEARED, 6'sd0, 16'sd0}},
    '{OP_MATCH, 18'sd0, 16'sd0, 16'sd0, 6'd1, 1'b1, '{STAT_MATCHED, -6'sd1, 16'sd0}},
    // Field extremes.
    '{OP_LOAD, 18'sd131071, 16'sd32767, 16'sd32767, 6'd1, 1'b1,
      '{STAT_STORED, 6'sd0, 16'sd0}},
    '{OP_LOAD, -18'sd131072, -16'sd32768, -16'sd32768, 6'd1, 1'b1,
      '{STAT_STORED, 6'sd0, 16'sd0}},
    '{OP_MATCH, 18'sd131071, 16'sd32767, 16'sd0, 6'd1, 1'b1,
      '{STAT_MATCHED, 6'sd0, 16'sd32767}},
    '{OP_MATCH, -18'sd131072, -16'sd32768, 16'sd0, 6'd1, 1'b1,
      '{STAT_MATCHED, 6'sd1, -16'sd32768}},
    // Phi difference wrapping across the half turn.
    '{OP_MATCH, -18'sd131072, 16'sd32767, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    '{OP_MATCH, 18'sd0, 16'sd0, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    // Fill the store to capacity, then overflow it.
    '{OP_LOAD, 18'sd1000, 16'sd1000, 16'sd5, 6'd30, 1'b0, NO_ANSWER},
    '{OP_LOAD, 18'sd7, 16'sd7, 16'sd7, 6'd1, 1'b1, '{STAT_FULL, 6'sd0, 16'sd0}},
    '{OP_MATCH, 18'sd1000, 16'sd1000, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    // Just inside and just outside the default threshold.
    '{OP_MATCH, 18'sd3086, 16'sd1024, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    '{OP_MATCH, 18'sd3086, 16'sd1025, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    '{OP_LOAD, 18'sd9, 16'sd9, 16'sd9, 6'd1, 1'b1, '{STAT_FULL, 6'sd0, 16'sd0}},
    '{OP_CLEAR, 18'sd1, 16'sd1, 16'sd1, 6'd1, 1'b1, '{STAT_CLEARED, 6'sd0, 16'sd0}},
    '{OP_MATCH, 18'sd1000, 16'sd1000, 16'sd0, 6'd1, 1'b1,
      '{STAT_MATCHED, -6'sd1, 16'sd0}},
    '{OP_LOAD, 18'sd0, -16'sd1, -16'sd1, 6'd1, 1'b0, NO_ANSWER},
    '{OP_MATCH, 18'sd0, 16'sd0, 16'sd0, 6'd1, 1'b0, NO_ANSWER},
    '{OP_MATCH, 18'sd200, -16'sd200, 16'sd0, 6'd1, 1'b0, NO_ANSWER}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [THRESH_W-1:0] cfg_wdata;

  drcm_in_if  in_ch ();
  drcm_out_if out_ch ();

  delta_r_first_cluster_match i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: the cluster store, its fill count and the threshold.
  logic signed [ETA_W-1:0]  cl_eta  [N_CLUSTERS];
  logic signed [PHI_W-1:0]  cl_phi  [N_CLUSTERS];
  logic signed [TIME_W-1:0] cl_time [N_CLUSTERS];
  int                       cl_count;
  logic [THRESH_W-1:0]      dist_limit;

  cluster_answer_t pending_answers [$];
  cluster_answer_t oldest_answer;
  bit              calm;
  int              n_errors, n_sent, n_hits, n_misses, n_full, n_settings;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Works out the answer to one item and updates the predictor state.
  function automatic bit first_cluster_answer(input logic [OP_W-1:0] op,
                                              input logic signed [ETA_W-1:0] eta,
                                              input logic signed [PHI_W-1:0] phi,
                                              input logic signed [TIME_W-1:0] tv,
                                              output cluster_answer_t ans);
    int                      de;
    logic signed [PHI_W-1:0] dp;
    longint                  d2;
    ans = NO_ANSWER;
    case (op)
      OP_CLEAR: begin
        cl_count = 0;
        return 1'b1;
      end
      OP_LOAD: begin
        if (cl_count >= N_CLUSTERS) begin
          ans.status = STAT_FULL;
        end else begin
          cl_eta[cl_count]  = eta;
          cl_phi[cl_count]  = phi;
          cl_time[cl_count] = tv;
          cl_count++;
          ans.status = STAT_STORED;
        end
        return 1'b1;
      end
      OP_MATCH: begin
        ans.status      = STAT_MATCHED;
        ans.match_index = -6'sd1;
        for (int i = 0; i < cl_count; i++) begin
          de = int'(eta) - int'(cl_eta[i]);
          dp = phi - cl_phi[i];
          d2 = longint'(de) * longint'(de) + longint'(dp) * longint'(dp);
          if (d2 < longint'(dist_limit)) begin
            ans.match_index = INDEX_W'(i);
            ans.match_time  = cl_time[i];
            break;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item, after a random gap unless calm, and records its answer once accepted.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [ETA_W-1:0] eta,
                           input logic signed [PHI_W-1:0] phi,
                           input logic signed [TIME_W-1:0] tv,
                           input bit typed,
                           input cluster_answer_t typed_ans);
    cluster_answer_t ans;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.eta        <= eta;
    in_ch.phi        <= phi;
    in_ch.time_value <= tv;
    do @(posedge clk); while (!in_ch.ready);
    if (first_cluster_answer(op, eta, phi, tv, ans)) begin
      pending_answers.push_back(typed ? typed_ans : ans);
      n_sent++;
    end
  endtask

  // Holds the sender until every result has come and the block has settled.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    dist_limit  = value;
    n_settings++;
  endtask

  function automatic int offset_within(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // One event: a clear, a run of loads and a few photon queries, or else some noise.
  task automatic run_event(input int span);
    int                      n_loads, k;
    bit                      bunched;
    logic signed [ETA_W-1:0] e, e_centre;
    logic signed [PHI_W-1:0] p, p_centre;
    if ($urandom_range(0, 99) < 80) begin
      send_item(OP_CLEAR, ETA_W'($urandom), PHI_W'($urandom), TIME_W'($urandom),
                1'b0, NO_ANSWER);
      n_loads  = ($urandom_range(0, 9) == 0) ? $urandom_range(N_CLUSTERS - 6, N_CLUSTERS + 3)
                                             : $urandom_range(1, 8);
      bunched  = 1'($urandom_range(0, 1));
      e_centre = ETA_W'($urandom);
      p_centre = PHI_W'($urandom);
      repeat (n_loads) begin
        if (bunched) begin
          e = e_centre + ETA_W'(offset_within(2 * span));
          p = p_centre + PHI_W'(offset_within(2 * span));
        end else begin
          e = ETA_W'($urandom);
          p = PHI_W'($urandom);
        end
        send_item(OP_LOAD, e, p, TIME_W'($urandom), 1'b0, NO_ANSWER);
      end
      repeat ($urandom_range(1, 6)) begin
        if (cl_count != 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, cl_count - 1);
          e = cl_eta[k] + ETA_W'(offset_within(span));
          p = cl_phi[k] + PHI_W'(offset_within(span));
        end else begin
          e = ETA_W'($urandom);
          p = PHI_W'($urandom);
        end
        send_item(OP_MATCH, e, p, TIME_W'($urandom), 1'b0, NO_ANSWER);
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_item(OP_W'($urandom_range(OP_CLEAR, OP_UNUSED)), ETA_W'($urandom),
                  PHI_W'($urandom), TIME_W'($urandom), 1'b0, NO_ANSWER);
      end
    end
  endtask

  // Threshold for each phase of the random part, extremes among them.
  function automatic logic [THRESH_W-1:0] threshold_for_phase(input int phase);
    case (phase % 7)
      0:       return THRESH_RESET;
      1:       return '0;
      2:       return THRESH_MAX;
      3:       return 37'd2;
      4:       return THRESH_W'($urandom_range(1, 1 << 20));
      5:       return THRESH_W'({$urandom, $urandom});
      default: return THRESH_RESET;
    endcase
  endfunction

  // Result side: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result item arrived with nothing pending");
        end else begin
          oldest_answer = pending_answers.pop_front();
          if (out_ch.status !== oldest_answer.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_ch.status, oldest_answer.status));
          if (out_ch.match_index !== oldest_answer.match_index)
            report_mismatch($sformatf("match_index %0d, expected %0d",
                                      out_ch.match_index, oldest_answer.match_index));
          if (out_ch.match_time !== oldest_answer.match_time)
            report_mismatch($sformatf("match_time %0d, expected %0d",
                                      out_ch.match_time, oldest_answer.match_time));
          if (oldest_answer.status == STAT_FULL) n_full++;
          if (oldest_answer.status == STAT_MATCHED) begin
            if (oldest_answer.match_index == -6'sd1) n_misses++;
            else n_hits++;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Main sequence: reset, directed table, then random phases over several thresholds.
  initial begin
    int phase, phase_start, span;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_CLEAR;
    in_ch.eta        = '0;
    in_ch.phi        = '0;
    in_ch.time_value = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cl_count         = 0;
    dist_limit       = THRESH_RESET;
    calm             = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      repeat (DIRECTED_ROWS[r].reps) begin
        send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].eta, DIRECTED_ROWS[r].phi,
                  DIRECTED_ROWS[r].tv, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].ans);
      end
    end

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      wait_until_drained();
      write_threshold(threshold_for_phase(phase));
      span = int'($sqrt(real'(dist_limit))) + 2;
      if (span > 200000) span = 200000;
      calm = (phase == 4);
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS && n_sent < ITEM_TARGET) run_event(span);
      phase++;
    end
    calm = 1'b0;

    wait_until_drained();
    $display("Run covered %0d result items over %0d threshold settings.", n_sent, n_settings);
    $display("Queries: %0d matched, %0d unmatched; %0d loads dropped on a full store.",
             n_hits, n_misses, n_full);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
